// ===== src/bcd_pkg.sv =====
// shared types and constants of the button click detector
`timescale 1ns / 1ps
package bcd_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned QueueDepth = 2;
  localparam logic [15:0] DefaultRepeatDelay = 16'd500;

  typedef enum logic [2:0] {
    ST_OFF = 3'd0, ST_ON = 3'd1, ST_UP_OFF = 3'd2, ST_UP_ON = 3'd3,
    ST_DN_ON = 3'd4, ST_DN_OFF = 3'd5
  } click_state_t;

  typedef enum logic [2:0] {
    EV_DOWN = 3'd0, EV_UP = 3'd1, EV_SINGLE = 3'd2, EV_DOUBLE = 3'd3,
    EV_LONG = 3'd4, EV_FDOWN = 3'd5, EV_FUP = 3'd6
  } event_t;

  typedef enum logic [2:0] {
    REG_THRESH = 3'd0, REG_MODE = 3'd1, REG_LONG = 3'd2, REG_DBL = 3'd3,
    REG_RPT_INT = 3'd4, REG_RPT_DLY = 3'd5, REG_FDOWN = 3'd6, REG_FUP = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] thresh;
    logic [1:0]  mode;
    logic [15:0] long_ms;
    logic [15:0] dbl_ms;
    logic [15:0] rpt_int;
    logic [15:0] rpt_dly;
    logic [15:0] fdown_ms;
    logic [15:0] fup_ms;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic tick;
    logic edge_hit;
    logic down;
  } cmd_t;

  typedef struct packed {
    logic        act;
    logic [15:0] left;
  } tmr_t;

endpackage

// ===== src/bcd_regs.sv =====
// configuration register file with apb-style access
`timescale 1ns / 1ps
module bcd_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [bcd_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output bcd_pkg::cfg_t                cfg
);
  bcd_pkg::cfg_t cfg_r;
  logic [2:0] idx;
  logic wr;

  assign idx = cfg_paddr[4:2];
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh   <= 32'h0001_0000;
      cfg_r.mode     <= 2'd2;
      cfg_r.long_ms  <= '0;
      cfg_r.dbl_ms   <= '0;
      cfg_r.rpt_int  <= '0;
      cfg_r.rpt_dly  <= bcd_pkg::DefaultRepeatDelay;
      cfg_r.fdown_ms <= '0;
      cfg_r.fup_ms   <= '0;
    end else if (wr) begin
      case (bcd_pkg::reg_idx_t'(idx))
        bcd_pkg::REG_THRESH:  cfg_r.thresh   <= cfg_pwdata;
        bcd_pkg::REG_MODE:    cfg_r.mode     <= cfg_pwdata[1:0];
        bcd_pkg::REG_LONG:    cfg_r.long_ms  <= cfg_pwdata[15:0];
        bcd_pkg::REG_DBL:     cfg_r.dbl_ms   <= cfg_pwdata[15:0];
        bcd_pkg::REG_RPT_INT: cfg_r.rpt_int  <= cfg_pwdata[15:0];
        bcd_pkg::REG_RPT_DLY: cfg_r.rpt_dly  <= cfg_pwdata[15:0];
        bcd_pkg::REG_FDOWN:   cfg_r.fdown_ms <= cfg_pwdata[15:0];
        bcd_pkg::REG_FUP:     cfg_r.fup_ms   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (bcd_pkg::reg_idx_t'(idx))
      bcd_pkg::REG_THRESH:  cfg_prdata = cfg_r.thresh;
      bcd_pkg::REG_MODE:    cfg_prdata = {30'd0, cfg_r.mode};
      bcd_pkg::REG_LONG:    cfg_prdata = {16'd0, cfg_r.long_ms};
      bcd_pkg::REG_DBL:     cfg_prdata = {16'd0, cfg_r.dbl_ms};
      bcd_pkg::REG_RPT_INT: cfg_prdata = {16'd0, cfg_r.rpt_int};
      bcd_pkg::REG_RPT_DLY: cfg_prdata = {16'd0, cfg_r.rpt_dly};
      bcd_pkg::REG_FDOWN:   cfg_prdata = {16'd0, cfg_r.fdown_ms};
      bcd_pkg::REG_FUP:     cfg_prdata = {16'd0, cfg_r.fup_ms};
      default:              cfg_prdata = '0;
    endcase
  end
endmodule

// ===== src/bcd_front.sv =====
// front end: sample edge classification and a short command queue
`timescale 1ns / 1ps
module bcd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tuser,
  input  logic [15:0]        in_tdata,
  input  bcd_pkg::cfg_t      cfg,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output bcd_pkg::cmd_t      cmd
);
  bcd_pkg::cmd_t q_r [bcd_pkg::QueueDepth];
  logic [1:0] cnt_r;
  logic rd_r, wr_r;
  logic signed [15:0] prev_r, v, rel, prs;
  logic push, pop, press, relse;
  bcd_pkg::cmd_t c;

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[rd_r];

  assign v = in_tdata;
  assign rel = cfg.thresh[15:0];
  assign prs = cfg.thresh[31:16];
  assign press = (prev_r < prs) && (v >= prs);
  assign relse = !press && (prev_r > rel) && (v <= rel);

  always_comb begin
    c.tick = in_tuser;
    c.edge_hit = !in_tuser && (press || relse);
    c.down = press ? !cfg.mode[0] : cfg.mode[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      prev_r <= '0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
        if (!in_tuser) prev_r <= v;
      end
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= c;
  end
endmodule

// ===== src/bcd_back.sv =====
// back end: click state machine, timers and event output register
`timescale 1ns / 1ps
module bcd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  bcd_pkg::cmd_t      cmd,
  input  bcd_pkg::cfg_t      cfg,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [2:0]         out_tdata,
  output logic               out_tlast
);
  bcd_pkg::click_state_t st_r, st_nxt;
  logic [15:0] since_r, since_nxt;
  bcd_pkg::tmr_t lp_r, lp_nxt, dc_r, dc_nxt, rp_r, rp_nxt, fd_r, fd_nxt, fu_r, fu_nxt;
  // pending events of the current command, drained one per cycle while the output is not stalled
  logic [2:0] ev_r [5];
  logic [2:0] ev_nxt [5];
  logic [2:0] n_r, n_nxt, k_r;
  logic take, busy, step;
  logic f_dc, f_lp, f_rp, f_fd, f_fu;
  logic [15:0] lp_arm;
  logic [2:0] ki;

  assign busy = (k_r != n_r);
  // output register free or being drained
  assign step = busy && (!out_tvalid || out_tready);
  assign cmd_ready = !busy;
  assign take = cmd_valid && cmd_ready;

  function automatic bcd_pkg::tmr_t arm_t(input logic [15:0] ms);
    bcd_pkg::tmr_t t;
    t.act = 1'b1;
    t.left = (ms == 16'd0) ? 16'd1 : ms;
    return t;
  endfunction

  function automatic logic fires(input bcd_pkg::tmr_t t);
    return t.act && (t.left <= 16'd1);
  endfunction

  function automatic bcd_pkg::tmr_t dec_t(input bcd_pkg::tmr_t t);
    bcd_pkg::tmr_t r;
    r = t;
    if (t.act) begin
      if (t.left > 16'd1) r.left = t.left - 16'd1;
      else r.act = 1'b0;
    end
    return r;
  endfunction

  always_comb begin
    st_nxt = st_r; since_nxt = since_r;
    lp_nxt = lp_r; dc_nxt = dc_r; rp_nxt = rp_r; fd_nxt = fd_r; fu_nxt = fu_r;
    for (int i = 0; i < 5; i++) ev_nxt[i] = ev_r[i];
    n_nxt = 3'd0;
    f_dc = fires(dc_r); f_lp = fires(lp_r); f_rp = fires(rp_r);
    f_fd = fires(fd_r); f_fu = fires(fu_r);
    lp_arm = (cfg.long_ms > since_r) ? cfg.long_ms - since_r : 16'd1;
    if (cmd.tick) begin
      if (since_r != 16'hFFFF) since_nxt = since_r + 16'd1;
      dc_nxt = dec_t(dc_r); lp_nxt = dec_t(lp_r); rp_nxt = dec_t(rp_r);
      fd_nxt = dec_t(fd_r); fu_nxt = dec_t(fu_r);
      if (f_dc) begin
        ev_nxt[n_nxt] = bcd_pkg::EV_SINGLE; n_nxt = n_nxt + 3'd1;
        if (st_r == bcd_pkg::ST_DN_OFF || st_r == bcd_pkg::ST_UP_OFF) st_nxt = bcd_pkg::ST_OFF;
        else if (st_r == bcd_pkg::ST_DN_ON || st_r == bcd_pkg::ST_UP_ON) st_nxt = bcd_pkg::ST_ON;
      end
      if (f_lp) begin
        ev_nxt[n_nxt] = bcd_pkg::EV_LONG; n_nxt = n_nxt + 3'd1;
        st_nxt = bcd_pkg::ST_OFF;
      end
      if (f_rp) begin
        ev_nxt[n_nxt] = bcd_pkg::EV_DOWN; n_nxt = n_nxt + 3'd1;
        if (cfg.rpt_int != 16'd0) rp_nxt = arm_t(cfg.rpt_int);
      end
      if (f_fd) begin ev_nxt[n_nxt] = bcd_pkg::EV_FDOWN; n_nxt = n_nxt + 3'd1; end
      if (f_fu) begin ev_nxt[n_nxt] = bcd_pkg::EV_FUP; n_nxt = n_nxt + 3'd1; end
    end else if (cmd.edge_hit) begin
      if (cfg.rpt_int != 16'd0) begin
        if (cmd.down)
          rp_nxt = arm_t((cfg.rpt_dly != 16'd0) ? cfg.rpt_dly : bcd_pkg::DefaultRepeatDelay);
        else rp_nxt.act = 1'b0;
      end
      if (cfg.fdown_ms != 16'd0 && cmd.down && !fd_r.act) fd_nxt = arm_t(cfg.fdown_ms);
      if (cfg.fup_ms != 16'd0 && !cmd.down && !fu_r.act) fu_nxt = arm_t(cfg.fup_ms);
      case (st_r)
        bcd_pkg::ST_OFF: if (cmd.down) begin
          since_nxt = '0;
          ev_nxt[0] = bcd_pkg::EV_DOWN; n_nxt = 3'd1;
          if (cfg.long_ms != 16'd0) lp_nxt = arm_t(cfg.long_ms);
          if (cfg.dbl_ms != 16'd0 && !cfg.mode[1]) begin
            st_nxt = bcd_pkg::ST_DN_ON; dc_nxt = arm_t(cfg.dbl_ms);
          end else st_nxt = bcd_pkg::ST_ON;
        end
        bcd_pkg::ST_ON: if (!cmd.down) begin
          ev_nxt[0] = bcd_pkg::EV_UP; n_nxt = 3'd1;
          lp_nxt.act = 1'b0;
          st_nxt = bcd_pkg::ST_OFF;
          if (cfg.dbl_ms != 16'd0 && cfg.mode[1]) begin
            if (since_r < cfg.dbl_ms) begin
              st_nxt = bcd_pkg::ST_UP_OFF; dc_nxt = arm_t(cfg.dbl_ms - since_r);
            end else begin
              ev_nxt[1] = bcd_pkg::EV_SINGLE; n_nxt = 3'd2;
            end
          end
        end
        bcd_pkg::ST_UP_OFF: if (cmd.down) begin
          ev_nxt[0] = bcd_pkg::EV_DOWN; n_nxt = 3'd1;
          if (cfg.long_ms != 16'd0) lp_nxt = arm_t(lp_arm);
          st_nxt = bcd_pkg::ST_UP_ON;
        end
        bcd_pkg::ST_UP_ON: if (!cmd.down) begin
          ev_nxt[0] = bcd_pkg::EV_UP; ev_nxt[1] = bcd_pkg::EV_DOUBLE; n_nxt = 3'd2;
          dc_nxt.act = 1'b0; lp_nxt.act = 1'b0;
          st_nxt = bcd_pkg::ST_OFF;
        end
        bcd_pkg::ST_DN_ON: if (!cmd.down) begin
          ev_nxt[0] = bcd_pkg::EV_UP; n_nxt = 3'd1;
          lp_nxt.act = 1'b0;
          st_nxt = bcd_pkg::ST_DN_OFF;
        end
        bcd_pkg::ST_DN_OFF: if (cmd.down) begin
          ev_nxt[0] = bcd_pkg::EV_DOWN; ev_nxt[1] = bcd_pkg::EV_DOUBLE; n_nxt = 3'd2;
          dc_nxt.act = 1'b0; since_nxt = '0;
          st_nxt = bcd_pkg::ST_ON;
          if (cfg.long_ms != 16'd0) lp_nxt = arm_t(cfg.long_ms);
        end
        default: ;
      endcase
    end
  end

  assign ki = (k_r > 3'd4) ? 3'd4 : k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bcd_pkg::ST_OFF;
      since_r <= '0;
      lp_r <= '0; dc_r <= '0; rp_r <= '0; fd_r <= '0; fu_r <= '0;
      n_r <= '0; k_r <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (take) begin
        st_r <= st_nxt; since_r <= since_nxt;
        lp_r <= lp_nxt; dc_r <= dc_nxt; rp_r <= rp_nxt; fd_r <= fd_nxt; fu_r <= fu_nxt;
        n_r <= n_nxt; k_r <= 3'd0;
      end else if (step) begin
        k_r <= k_r + 3'd1;
      end
      if (step) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) for (int i = 0; i < 5; i++) ev_r[i] <= ev_nxt[i];
    if (step) begin
      out_tdata <= ev_r[ki];
      out_tlast <= (k_r + 3'd1 == n_r);
    end
  end
endmodule

// ===== src/button_click_detector.sv =====
// top level of the button click detector
`timescale 1ns / 1ps
// button click detector
// input stream: in_tuser is the item kind (0 sample, 1 millisecond tick),
//   in_tdata carries the signed 16-bit sample value
// result stream: out_tdata carries the 3-bit event code, zero-filled, out_tlast marks the last
//   event caused by one input item; an input may cause no event at all
// configuration: apb-style port, eight registers at byte address 4*i; the user
//   writes them only while the block is idle, which the block itself does not enforce; reads return the register value
// front end compares each sample against the hysteresis pair and queues a
//   classified command in a two-entry queue
// back end runs the click machine and timers: it takes a command, then passes
//   its events one at a time through the output register
// an input item passes the command queue, then the back end, then the output register
// throughput: an item every cycle when it makes no event; an item with events
//   holds the next one until they are through the single event output register
// reset (synchronous, rst_n low) restores register defaults, idles the click
//   machine and disarms all timers
// a stalled receiver holds the output register; the queue fills and then
//   in_tready drops
module button_click_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // value
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // event_code, zero fill
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  bcd_pkg::cfg_t cfg;
  bcd_pkg::cmd_t cmd;
  logic cmd_valid, cmd_ready;
  logic [2:0] ev;

  assign cfg_pready = 1'b1;
  assign out_tdata = {5'd0, ev};

  bcd_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg
  );

  bcd_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata, .cfg,
    .cmd_valid, .cmd_ready, .cmd
  );

  bcd_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .cfg,
    .out_tvalid, .out_tready, .out_tdata(ev), .out_tlast
  );
endmodule

// ===== dv/bcd_checker.sv =====
// watches the button click detector channels, predicts events and compares
`timescale 1ns / 1ps
module bcd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fails,
  output int          pending
);

  localparam int T_DBL = 0, T_LONG = 1, T_RPT = 2, T_FDN = 3, T_FUP = 4;

  typedef struct {
    bcd_pkg::event_t code;
    logic            last;
  } expected_event_t;

  expected_event_t  due_events[$];
  bcd_pkg::event_t  batch[$];

  logic [31:0]           regs [bcd_pkg::NumRegs];
  bcd_pkg::click_state_t cstate;
  int                    prev_val;
  int                    since_press;
  bit                    tmr_act [5];
  int                    tmr_left [5];

  assign pending = due_events.size();

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fails++;
  endtask

  function automatic void add_ev(input bcd_pkg::event_t e);
    batch.insert(batch.size(), e);
  endfunction

  function automatic void add_due(input bcd_pkg::event_t code, input logic last);
    expected_event_t e;
    e.code = code;
    e.last = last;
    due_events.insert(due_events.size(), e);
  endfunction

  function automatic void arm(input int t, input int ms);
    tmr_act[t] = 1'b1;
    tmr_left[t] = (ms == 0) ? 1 : ms;
  endfunction

  function automatic bit expire(input int t);
    if (!tmr_act[t]) return 1'b0;
    if (tmr_left[t] > 1) begin
      tmr_left[t]--;
      return 1'b0;
    end
    tmr_act[t] = 1'b0;
    return 1'b1;
  endfunction

  function automatic void reset_model();
    regs[bcd_pkg::REG_THRESH]  = 32'h0001_0000;
    regs[bcd_pkg::REG_MODE]    = 32'd2;
    regs[bcd_pkg::REG_LONG]    = 32'd0;
    regs[bcd_pkg::REG_DBL]     = 32'd0;
    regs[bcd_pkg::REG_RPT_INT] = 32'd0;
    regs[bcd_pkg::REG_RPT_DLY] = 32'd500;
    regs[bcd_pkg::REG_FDOWN]   = 32'd0;
    regs[bcd_pkg::REG_FUP]     = 32'd0;
    cstate = bcd_pkg::ST_OFF;
    prev_val = 0;
    since_press = 0;
    for (int i = 0; i < 5; i++) begin
      tmr_act[i] = 1'b0;
      tmr_left[i] = 0;
    end
  endfunction

  // hysteresis edge detection followed by the click machine
  function automatic void sample_step(input logic [15:0] raw);
    int  v, prev, rel, prs, lp, dc;
    bit  neg, on_up, down;
    v = int'($signed(raw));
    prev = prev_val;
    rel = int'($signed(regs[bcd_pkg::REG_THRESH][15:0]));
    prs = int'($signed(regs[bcd_pkg::REG_THRESH][31:16]));
    neg = regs[bcd_pkg::REG_MODE][0];
    on_up = regs[bcd_pkg::REG_MODE][1];
    lp = int'(regs[bcd_pkg::REG_LONG][15:0]);
    dc = int'(regs[bcd_pkg::REG_DBL][15:0]);
    prev_val = v;
    if (prev < prs && v >= prs) down = !neg;
    else if (prev > rel && v <= rel) down = neg;
    else return;

    if (regs[bcd_pkg::REG_RPT_INT][15:0] != 0) begin
      if (down) arm(T_RPT, (regs[bcd_pkg::REG_RPT_DLY][15:0] != 0)
                           ? int'(regs[bcd_pkg::REG_RPT_DLY][15:0])
                           : int'(bcd_pkg::DefaultRepeatDelay));
      else tmr_act[T_RPT] = 1'b0;
    end
    if (regs[bcd_pkg::REG_FDOWN][15:0] != 0 && down && !tmr_act[T_FDN])
      arm(T_FDN, int'(regs[bcd_pkg::REG_FDOWN][15:0]));
    if (regs[bcd_pkg::REG_FUP][15:0] != 0 && !down && !tmr_act[T_FUP])
      arm(T_FUP, int'(regs[bcd_pkg::REG_FUP][15:0]));

    case (cstate)
      bcd_pkg::ST_OFF: if (down) begin
        since_press = 0;
        add_ev(bcd_pkg::EV_DOWN);
        if (lp != 0) arm(T_LONG, lp);
        if (dc != 0 && !on_up) begin
          cstate = bcd_pkg::ST_DN_ON;
          arm(T_DBL, dc);
        end else begin
          cstate = bcd_pkg::ST_ON;
        end
      end
      bcd_pkg::ST_ON: if (!down) begin
        add_ev(bcd_pkg::EV_UP);
        tmr_act[T_LONG] = 1'b0;
        if (dc != 0 && on_up) begin
          if (since_press < dc) begin
            cstate = bcd_pkg::ST_UP_OFF;
            arm(T_DBL, dc - since_press);
          end else begin
            add_ev(bcd_pkg::EV_SINGLE);
            cstate = bcd_pkg::ST_OFF;
          end
        end else begin
          cstate = bcd_pkg::ST_OFF;
        end
      end
      bcd_pkg::ST_UP_OFF: if (down) begin
        add_ev(bcd_pkg::EV_DOWN);
        // long press still measured from the first press
        if (lp != 0) arm(T_LONG, (lp > since_press) ? lp - since_press : 1);
        cstate = bcd_pkg::ST_UP_ON;
      end
      bcd_pkg::ST_UP_ON: if (!down) begin
        add_ev(bcd_pkg::EV_UP);
        add_ev(bcd_pkg::EV_DOUBLE);
        tmr_act[T_DBL] = 1'b0;
        tmr_act[T_LONG] = 1'b0;
        cstate = bcd_pkg::ST_OFF;
      end
      bcd_pkg::ST_DN_ON: if (!down) begin
        add_ev(bcd_pkg::EV_UP);
        tmr_act[T_LONG] = 1'b0;
        cstate = bcd_pkg::ST_DN_OFF;
      end
      bcd_pkg::ST_DN_OFF: if (down) begin
        add_ev(bcd_pkg::EV_DOWN);
        add_ev(bcd_pkg::EV_DOUBLE);
        tmr_act[T_DBL] = 1'b0;
        since_press = 0;
        cstate = bcd_pkg::ST_ON;
        if (lp != 0) arm(T_LONG, lp);
      end
      default: ;
    endcase
  endfunction

  function automatic void tick_step();
    bit f_dc, f_lp, f_rp, f_fd, f_fu;
    if (since_press < 65535) since_press++;
    f_dc = expire(T_DBL);
    f_lp = expire(T_LONG);
    f_rp = expire(T_RPT);
    f_fd = expire(T_FDN);
    f_fu = expire(T_FUP);
    if (f_dc) begin
      add_ev(bcd_pkg::EV_SINGLE);
      if (cstate == bcd_pkg::ST_DN_OFF || cstate == bcd_pkg::ST_UP_OFF)
        cstate = bcd_pkg::ST_OFF;
      else if (cstate == bcd_pkg::ST_DN_ON || cstate == bcd_pkg::ST_UP_ON)
        cstate = bcd_pkg::ST_ON;
    end
    if (f_lp) begin
      add_ev(bcd_pkg::EV_LONG);
      cstate = bcd_pkg::ST_OFF;
    end
    if (f_rp) begin
      add_ev(bcd_pkg::EV_DOWN);
      // zero interval at expiry still sends the down, then stops
      if (regs[bcd_pkg::REG_RPT_INT][15:0] != 0)
        arm(T_RPT, int'(regs[bcd_pkg::REG_RPT_INT][15:0]));
    end
    if (f_fd) add_ev(bcd_pkg::EV_FDOWN);
    if (f_fu) add_ev(bcd_pkg::EV_FUP);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      due_events.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (bcd_pkg::reg_idx_t'(cfg_paddr[4:2]))
          bcd_pkg::REG_THRESH: regs[bcd_pkg::REG_THRESH] = cfg_pwdata;
          bcd_pkg::REG_MODE:   regs[bcd_pkg::REG_MODE] = {30'd0, cfg_pwdata[1:0]};
          default:             regs[cfg_paddr[4:2]] = {16'd0, cfg_pwdata[15:0]};
        endcase
      end
      if (in_tvalid && in_tready) begin
        batch.delete();
        if (!in_tuser) sample_step(in_tdata);
        else tick_step();
        foreach (batch[i]) add_due(batch[i], i == batch.size() - 1);
      end
      if (out_tvalid && out_tready) begin
        if (due_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event %0d", out_tdata));
        end else begin
          if (out_tdata !== {5'd0, due_events[0].code})
            report_mismatch($sformatf("event code %0d, predicted %0d",
                                      out_tdata, due_events[0].code));
          if (out_tlast !== due_events[0].last)
            report_mismatch($sformatf("tlast %0b, predicted %0b",
                                      out_tlast, due_events[0].last));
          void'(due_events.pop_front());
        end
      end
    end
  end

endmodule

// ===== dv/tb_button_click_detector.sv =====
// testbench top: stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module tb_button_click_detector;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // value
  logic        in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // event_code, zero fill
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fails;
  int pending;
  bit quiet;        // no idling on either side while set
  int item_count;
  int press_lvl, release_lvl;   // current thresholds, signed

  button_click_detector i_dut (.*);

  bcd_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fails, .pending
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // receiver stalls about 17% of the cycles unless in a quiet stretch
  always @(posedge clk) out_tready <= quiet || ($urandom_range(99) >= 17);

  initial begin
    #2ms;
    $display("tb_button_click_detector: errors");
    $finish;
  end

  // a setup phase, then an access phase; the write lands on the access edge
  task automatic write_reg(input bcd_pkg::reg_idx_t idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // idle the block: every predicted event out, then room for a queued item
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_all(input logic [15:0] prs, input logic [15:0] rel,
                         input logic [1:0] mode, input logic [15:0] lp,
                         input logic [15:0] dc, input logic [15:0] ri,
                         input logic [15:0] rd, input logic [15:0] fd,
                         input logic [15:0] fu);
    drain();
    write_reg(bcd_pkg::REG_THRESH, {prs, rel});
    write_reg(bcd_pkg::REG_MODE, {30'd0, mode});
    write_reg(bcd_pkg::REG_LONG, {16'd0, lp});
    write_reg(bcd_pkg::REG_DBL, {16'd0, dc});
    write_reg(bcd_pkg::REG_RPT_INT, {16'd0, ri});
    write_reg(bcd_pkg::REG_RPT_DLY, {16'd0, rd});
    write_reg(bcd_pkg::REG_FDOWN, {16'd0, fd});
    write_reg(bcd_pkg::REG_FUP, {16'd0, fu});
    press_lvl = $signed(prs);
    release_lvl = $signed(rel);
  endtask

  // one input transfer, with an optional random gap before it
  task automatic send(input logic kind, input logic [15:0] val);
    if (!quiet && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= kind ? 16'($urandom) : val;
    do @(posedge clk); while (!in_tready);
    item_count++;
  endtask

  task automatic press();
    send(1'b0, 16'(press_lvl + $urandom_range(32767 - press_lvl)));
  endtask

  task automatic release_btn();
    send(1'b0, 16'(release_lvl - $urandom_range(release_lvl + 32768)));
  endtask

  task automatic ticks(input int n);
    repeat (n) send(1'b1, 16'd0);
  endtask

  function automatic logic [15:0] rand_ms();
    return ($urandom_range(99) < 20) ? 16'd0 : 16'($urandom_range(1, 9));
  endfunction

  initial begin
    int ph;
    int r;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    quiet = 1'b0;
    item_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme thresholds, press-decided double click
    set_all(16'h7fff, 16'h8000, 2'd0, 16'd3, 16'd5, 16'd2, 16'd0, 16'd1, 16'd2);
    send(1'b0, 16'h7fff);        // press
    send(1'b0, 16'h8000);        // release
    send(1'b0, 16'h7fff);        // second press inside the window: double on press
    ticks(4);                    // long press after a double click
    send(1'b0, 16'h8000);
    send(1'b0, 16'h0000);        // no edge
    send(1'b0, 16'h7fff);
    ticks(6);                    // long press, single click and follow events
    send(1'b0, 16'h8000);
    ticks(3);

    // directed: release-decided mode, second press after a long press
    set_all(16'd200, 16'd100, 2'd3, 16'd2, 16'd6, 16'd0, 16'd1, 16'd0, 16'd0);
    send(1'b0, 16'd250);         // negative polarity: this is an up edge
    send(1'b0, 16'd50);          // down
    ticks(3);
    send(1'b0, 16'd300);         // up
    send(1'b0, 16'd0);           // down, long press already due
    ticks(2);
    send(1'b0, 16'd300);
    ticks(7);                    // no click window is open: no event

    for (ph = 0; ph < 6; ph++) begin
      if (ph == 5)
        set_all(16'd150, 16'hff00, 2'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                16'hffff, 16'hffff);
      else
        set_all(16'($urandom_range(50, 400)), 16'(-$urandom_range(0, 300)),
                2'(ph), rand_ms(), rand_ms(), rand_ms(), rand_ms(), rand_ms(), rand_ms());
      quiet = (ph == 2);
      while (item_count < 30 + 40 * (ph + 1)) begin
        r = $urandom_range(99);
        if (r < 78) begin
          // well-formed gesture with random timing
          press();
          ticks($urandom_range(0, 10));
          release_btn();
          ticks($urandom_range(0, 10));
        end else if (r < 90) begin
          send(1'b0, 16'($urandom));
        end else begin
          ticks(1);
        end
        // hold off until every event is out, once in a while
        if (ph == 3 && item_count > 160 && item_count < 185) drain();
      end
      quiet = 1'b0;
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("tb_button_click_detector: clean");
    end else begin
      $display("tb_button_click_detector: errors");
    end
    $finish;
  end

endmodule
